FILE: hw/rtl/gafg_pkg.sv
// package: types, constants and helpers for the allele frequency block
`default_nettype none
package gafg_pkg;
  localparam int MAX_POPS = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int POP_W = 4;
  localparam int HALF_W = 19;
  localparam int OBS_W = 18;
  localparam int FREQ_W = 17;
  localparam int QUOT_W = 35;
  localparam logic [HALF_W-1:0] HALF_CAP = HALF_W'(4 * MAX_SAMPLES);
  localparam logic [OBS_W-1:0] OBS_CAP = OBS_W'(2 * MAX_SAMPLES);
  localparam logic [FREQ_W-1:0] Q16_ONE = FREQ_W'(65536);
  localparam logic [1:0] CODE_MISSING = 2'd1;

  typedef struct packed {
    logic [1:0] geno_code;
    logic [3:0] pop_index;
    logic       included;
    logic [1:0] sample_ploidy;
    logic       last_of_variant;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        out_pop;
    logic [FREQ_W-1:0] frequency;
    logic [OBS_W-1:0]  allele_count;
    logic              has_data;
    logic              last_in_run;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [HALF_W-1:0] alt;
    logic [OBS_W-1:0]  obs;
  } div_req_t;
endpackage
`default_nettype wire

FILE: hw/rtl/gafg_divider.sv
// divider: restoring division, one quotient bit per cycle
`default_nettype none
module gafg_divider (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire gafg_pkg::div_req_t     req,
  output logic                        done,
  output logic [gafg_pkg::FREQ_W-1:0] quot
);
  import gafg_pkg::*;
  logic              busy;
  logic [QUOT_W-1:0] num;
  logic [OBS_W:0]    rem;
  logic [OBS_W-1:0]  den;
  logic [5:0]        cnt;
  logic [OBS_W+1:0]  trial;
  logic [OBS_W:0]    shifted;

  assign shifted = {rem[OBS_W-1:0], num[QUOT_W-1]};
  assign trial = {1'b0, shifted} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      num <= {1'b0, req.alt, 15'b0};
      den <= req.obs;
      rem <= '0;
      cnt <= 6'(QUOT_W);
      done <= 1'b0;
    end else if (busy) begin
      if (trial[OBS_W+1]) begin
        rem <= shifted;
        num <= {num[QUOT_W-2:0], 1'b0};
      end else begin
        rem <= trial[OBS_W:0];
        num <= {num[QUOT_W-2:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      done <= (cnt == 6'd1);
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_comb begin
    if (den == '0) quot = '0;
    else if (num > QUOT_W'(Q16_ONE)) quot = Q16_ONE;
    else quot = num[FREQ_W-1:0];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/genotype_allele_frequency_by_group.sv
// top level: per-population allele frequency accumulator and reporter
//
// in channel: one sample per beat (in_valid/in_ready, payload in_data).
// out channel: one result per population in use (out_valid/out_ready).
// cfg channel: cfg_data[4:0] sets num_pops; write only while idle.
// a sample is handled as a memory read, then a modify and write back
// through the single accumulator memory port.
// on the last sample of a variant each population is read once and
// divided by a serial divider; the input is held off until the variant
// report is done and the valid bits of every population have been
// cleared.
// a stalled receiver holds the current result in the output register and
// the report pass waits. reset empties the accumulators at once through
// per-population valid bits and sets num_pops to 1.
// when the last sample is counted the report pass goes through S_RD
// first; otherwise it starts at S_DIVST.
`default_nettype none
module genotype_allele_frequency_by_group (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gafg_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gafg_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [4:0]          cfg_data
);
  import gafg_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_ACC, S_RD, S_DIVST, S_DIV, S_OUT} state_t;
  state_t state;
  logic [HALF_W-1:0] alt_mem [MAX_POPS];
  logic [OBS_W-1:0]  obs_mem [MAX_POPS];
  logic [MAX_POPS-1:0] live;
  logic [HALF_W-1:0] rd_alt;
  logic [OBS_W-1:0]  rd_obs;
  logic rd_live;
  logic [POP_W-1:0] rd_addr, pop, npops;
  logic [4:0] num_pops;
  in_item_t item;
  out_item_t res;
  logic [HALF_W-1:0] cur_alt, alt_next;
  logic [OBS_W-1:0]  cur_obs, obs_next;
  logic [1:0] dosage;
  logic [2:0] half;
  logic counted;
  div_req_t req;
  logic ddone;
  logic [FREQ_W-1:0] dquot;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign npops = (num_pops == 5'd0) ? '0 :
                 (num_pops > 5'd16) ? 4'd15 : 4'(num_pops - 5'd1);

  always_ff @(posedge clk) begin
    rd_alt <= alt_mem[rd_addr];
    rd_obs <= obs_mem[rd_addr];
    rd_live <= live[rd_addr];
  end

  assign cur_alt = rd_live ? rd_alt : '0;
  assign cur_obs = rd_live ? rd_obs : '0;

  always_comb begin
    logic [HALF_W:0] sa;
    logic [OBS_W:0] so;
    case (item.geno_code)
      2'd0: dosage = 2'd2;
      2'd2: dosage = 2'd1;
      default: dosage = 2'd0;
    endcase
    half = (item.sample_ploidy == 2'd2) ? {dosage, 1'b0} : {1'b0, dosage};
    counted = item.included && item.geno_code != CODE_MISSING &&
              (item.sample_ploidy == 2'd1 || item.sample_ploidy == 2'd2);
    sa = {1'b0, cur_alt} + (HALF_W+1)'(half);
    so = {1'b0, cur_obs} + (OBS_W+1)'(item.sample_ploidy);
    alt_next = (sa > {1'b0, HALF_CAP}) ? HALF_CAP : sa[HALF_W-1:0];
    obs_next = (so > {1'b0, OBS_CAP}) ? OBS_CAP : so[OBS_W-1:0];
  end

  always_comb begin
    rd_addr = (state == S_IDLE) ? in_data.pop_index : pop;
    if (state == S_ACC && item.last_of_variant) rd_addr = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live <= '0;
      num_pops <= 5'd1;
      out_valid <= 1'b0;
      pop <= '0;
      req.start <= 1'b0;
    end else begin
      if (cfg_valid) num_pops <= cfg_data;
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          pop <= in_data.pop_index;
          state <= S_ACC;
        end
        S_ACC: begin
          if (counted) begin
            alt_mem[pop] <= alt_next;
            obs_mem[pop] <= obs_next;
            live[pop] <= 1'b1;
          end
          if (item.last_of_variant) begin
            if (counted) begin
              pop <= '0;
              state <= S_RD;
            end else begin
              pop <= '0;
              state <= S_DIVST;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD: state <= S_DIVST;
        S_DIVST: begin
          req.start <= 1'b1;
          req.alt <= cur_alt;
          req.obs <= cur_obs;
          res.out_pop <= pop;
          res.allele_count <= cur_obs;
          res.has_data <= (cur_obs != '0);
          res.last_in_run <= (pop == npops);
          state <= S_DIV;
        end
        S_DIV: begin
          req.start <= 1'b0;
          if (ddone) begin
            res.frequency <= dquot;
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_data <= res;
          if (pop == npops) begin
            live <= '0;
            state <= S_IDLE;
          end else begin
            pop <= pop + 4'd1;
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gafg_divider u_div (
    .clk(clk), .rst(rst), .req(req), .done(ddone), .quot(dquot)
  );
endmodule
`default_nettype wire
